// ===== hdl/mpm_grid_to_particle_gather_core_defines.svh =====
// Assertion macros shared by the grid-to-particle gather RTL.
`ifndef MPM_GRID_TO_PARTICLE_GATHER_CORE_DEFINES_SVH
`define MPM_GRID_TO_PARTICLE_GATHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define MPM_G2P_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define MPM_G2P_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hdl/mpm_g2p_pkg.sv =====
// Types, constants and helper functions of the grid-to-particle gather.
`default_nettype none
package mpm_g2p_pkg;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_GATHER = 1'b1;

  localparam logic [7:0] GRID_CELLS_RESET = 8'd80;
  localparam int         GRID_CELLS_MIN   = 4;

  // Accumulator width: sixteen products of 22 by 32 bits with headroom.
  localparam int ACC_W = 58;

  // floor(q / 6) == (q * SPLINE_RECIP) >> SPLINE_SHIFT for every q below 2^19.
  localparam logic [18:0] SPLINE_RECIP = 19'd349526;
  localparam int          SPLINE_SHIFT = 21;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCALE,
    ST_SPLINE,
    ST_NODES,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Normalised distance of the particle from the node at stencil slot idx (offset idx - 1).
  function automatic logic signed [18:0] offset_dist(input logic [15:0] f,
                                                      input logic [1:0]  idx);
    logic [2:0] o;
    o = 3'(idx) - 3'd1;
    return $signed({3'b000, f}) - $signed({o, 16'h0000});
  endfunction

  function automatic logic [31:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + ACC_W'(32768)) >>> 16;
    if (r > $signed(ACC_W'(32'h7fff_ffff))) begin
      return 32'h7fff_ffff;
    end else if (r < -$signed(ACC_W'(33'h0_8000_0000))) begin
      return 32'h8000_0000;
    end else begin
      return r[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mpm_grid_to_particle_gather_core.sv =====
// Results: a gather's result is loaded into the output register from ST_FINISH, which waits while
// a held result has not been taken. Writes are taken one per cycle while idle; a new gather
// waits until the last one is done, as each takes eight passes through the spline pipeline
// and sixteen stencil reads through the single read port of the node memory.
// Reset: synchronous; afterwards the node memory is cleared one entry a cycle, every entry
// being zeroed before the first word is accepted.
`default_nettype none
`include "mpm_grid_to_particle_gather_core_defines.svh"
module mpm_grid_to_particle_gather_core
  import mpm_g2p_pkg::*;
#(
  parameter int MAX_GRID = 128
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata,      // grid_cells
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic         s_axis_tuser,   // command
  // node_x, node_y, node_vel_x, node_vel_y, particle_x, particle_y, two zero bits
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // vel_x, vel_y, affine_xx, affine_xy, affine_yx, affine_yy
  output logic [191:0]      m_axis_tdata
);

  localparam int AW  = $clog2(MAX_GRID);
  localparam int GW  = $clog2(MAX_GRID + 1);
  localparam int SW  = 24 + GW + 1;
  localparam int BXW = SW - 16 + 1;

  state_t state, state_next;

  logic [7:0]    grid_cells;
  logic [GW-1:0] g_eff;

  logic [2*AW-1:0] clr_addr;
  logic            clr_done;

  logic signed [23:0]   px, py;
  logic signed [SW-1:0] sx, sy;
  logic signed [BXW-1:0] bx, by;
  logic [15:0]          fx, fy;

  logic [3:0]  kcnt;
  logic [3:0]  ncnt;
  logic [15:0] wx [4];
  logic [15:0] wy [4];

  logic accept, accept_wr, accept_ga;
  logic sp_issue, node_issue, out_load;

  // spline pipeline
  logic [3:0]  sp_v;
  logic [16:0] sp1_a;
  logic        sp1_near;
  logic [2:0]  sp1_idx;
  logic [33:0] sp2_a2;
  logic [16:0] sp2_a;
  logic        sp2_near;
  logic [2:0]  sp2_idx;
  logic [48:0] sp3_a3;
  logic [32:0] sp3_a2;
  logic        sp3_near;
  logic [2:0]  sp3_idx;
  logic [18:0] sp4_q;
  logic [2:0]  sp4_idx;
  logic signed [18:0] sp_d;
  logic [18:0] sp_t;
  logic [52:0] sp_num;
  logic [37:0] sp_wfull;

  // node pipeline
  logic [4:0]  nv;
  logic        na_live;
  logic [31:0] na_wprod;
  logic signed [18:0] na_dx, na_dy;
  logic [15:0] nb_w;
  logic signed [18:0] nb_dx, nb_dy;
  logic signed [31:0] nb_vx, nb_vy;
  logic signed [35:0] nc_kxp, nc_kyp;
  logic signed [48:0] nc_wvx, nc_wvy;
  logic signed [31:0] nc_vx, nc_vy;
  logic signed [21:0] nd_kx, nd_ky;
  logic signed [48:0] nd_wvx, nd_wvy;
  logic signed [31:0] nd_vx, nd_vy;
  logic signed [53:0] ne_kxvx, ne_kyvx, ne_kxvy, ne_kyvy;
  logic signed [48:0] ne_wvx, ne_wvy;
  logic signed [ACC_W-1:0] acc [6];

  logic signed [BXW-1:0] nxs, nys;
  logic                  nx_ok, ny_ok;

  logic            ram_we;
  logic [2*AW-1:0] ram_waddr;
  logic [63:0]     ram_wdata;
  logic [63:0]     ram_rdata;
  logic [2*AW-1:0] ram_raddr;

  logic [6:0] in_node_x, in_node_y;

  assign in_node_x = s_axis_tdata[6:0];
  assign in_node_y = s_axis_tdata[13:7];

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign accept_wr = accept && (s_axis_tuser == CMD_WRITE);
  assign accept_ga = accept && (s_axis_tuser == CMD_GATHER);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cells <= GRID_CELLS_RESET;
    end else if (cfg_we) begin
      grid_cells <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(grid_cells) < GRID_CELLS_MIN) begin
      g_eff = GW'(GRID_CELLS_MIN);
    end else if (int'(grid_cells) > MAX_GRID) begin
      g_eff = GW'(MAX_GRID);
    end else begin
      g_eff = GW'(grid_cells);
    end
  end

  // ---------------------------------------------------------------- control
  assign clr_done = (clr_addr == '1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_done) state_next = ST_IDLE;
      ST_IDLE:   if (accept_ga) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SPLINE;
      ST_SPLINE: if (kcnt[3] && (sp_v == '0)) state_next = ST_NODES;
      ST_NODES:  if (ncnt == '1) state_next = ST_DRAIN;
      ST_DRAIN:  if (nv == '0) state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    sp_issue      = 1'b0;
    node_issue    = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SPLINE: sp_issue      = !kcnt[3];
      ST_NODES:  node_issue    = 1'b1;
      ST_FINISH: out_load      = !m_axis_tvalid || m_axis_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      kcnt     <= '0;
      ncnt     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_SCALE) begin
        kcnt <= '0;
      end else if (sp_issue) begin
        kcnt <= kcnt + 1'b1;
      end
      if (state == ST_SCALE) begin
        ncnt <= '0;
      end else if (node_issue) begin
        ncnt <= ncnt + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- position
  always_ff @(posedge clk) begin
    if (accept_ga) begin
      px <= $signed(s_axis_tdata[101:78]);
      py <= $signed(s_axis_tdata[125:102]);
    end
    if (state == ST_SCALE) begin
      sx <= SW'(px * $signed({1'b0, g_eff}));
      sy <= SW'(py * $signed({1'b0, g_eff}));
    end
  end

  assign bx = BXW'(sx >>> 16);
  assign by = BXW'(sy >>> 16);
  assign fx = sx[15:0];
  assign fy = sy[15:0];

  // ---------------------------------------------------------------- spline weights
  // Inside one cell the weight is t^3/2 - t^2 + 2/3, beyond it (2-t)^3/6; both share a^2, a^3.
  assign sp_d = offset_dist(kcnt[2] ? fy : fx, kcnt[1:0]);
  assign sp_t = sp_d[18] ? 19'(-sp_d) : 19'(sp_d);

  always_comb begin
    if (sp3_near) begin
      sp_num = 53'(3 * 53'(sp3_a3)) + (53'd1 << 50)
             - (53'(3 * 53'(sp3_a2)) << 17);
    end else begin
      sp_num = 53'(sp3_a3);
    end
  end

  assign sp_wfull = 38'(sp4_q * SPLINE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_v <= '0;
    end else begin
      sp_v <= {sp_v[2:0], sp_issue};
    end
  end

  always_ff @(posedge clk) begin
    sp1_near <= (sp_t < 19'd65536);
    sp1_a    <= (sp_t < 19'd65536) ? sp_t[16:0] : 17'(19'd131072 - sp_t);
    sp1_idx  <= kcnt[2:0];

    sp2_a2   <= 34'(sp1_a * sp1_a);
    sp2_a    <= sp1_a;
    sp2_near <= sp1_near;
    sp2_idx  <= sp1_idx;

    sp3_a3   <= 49'(sp2_a2 * sp2_a);
    sp3_a2   <= sp2_a2[32:0];
    sp3_near <= sp2_near;
    sp3_idx  <= sp2_idx;

    sp4_q    <= 19'((sp_num + (53'd3 << 32)) >> 32);
    sp4_idx  <= sp3_idx;

    if (sp_v[3]) begin
      if (sp4_idx[2]) begin
        wy[sp4_idx[1:0]] <= 16'(sp_wfull >> SPLINE_SHIFT);
      end else begin
        wx[sp4_idx[1:0]] <= 16'(sp_wfull >> SPLINE_SHIFT);
      end
    end
  end

  // ---------------------------------------------------------------- stencil walk
  assign nxs   = bx + $signed(BXW'(ncnt[3:2])) - $signed(BXW'(1));
  assign nys   = by + $signed(BXW'(ncnt[1:0])) - $signed(BXW'(1));
  assign nx_ok = !nxs[BXW-1] && (nxs < $signed(BXW'(g_eff)));
  assign ny_ok = !nys[BXW-1] && (nys < $signed(BXW'(g_eff)));

  assign ram_raddr = {nxs[AW-1:0], nys[AW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= '0;
    end else begin
      nv <= {nv[3:0], node_issue};
    end
  end

  always_ff @(posedge clk) begin
    na_live  <= nx_ok && ny_ok;
    na_wprod <= wx[ncnt[3:2]] * wy[ncnt[1:0]];
    na_dx    <= offset_dist(fx, ncnt[3:2]);
    na_dy    <= offset_dist(fy, ncnt[1:0]);

    // Off-grid nodes get a zero weight, which zeroes every product downstream.
    nb_w  <= na_live ? 16'((33'(na_wprod) + 33'd32768) >> 16) : 16'd0;
    nb_dx <= na_dx;
    nb_dy <= na_dy;
    nb_vx <= $signed(ram_rdata[31:0]);
    nb_vy <= $signed(ram_rdata[63:32]);

    nc_kxp <= 36'($signed({1'b0, nb_w}) * nb_dx);
    nc_kyp <= 36'($signed({1'b0, nb_w}) * nb_dy);
    nc_wvx <= 49'($signed({1'b0, nb_w}) * nb_vx);
    nc_wvy <= 49'($signed({1'b0, nb_w}) * nb_vy);
    nc_vx  <= nb_vx;
    nc_vy  <= nb_vy;

    nd_kx  <= 22'(((38'(nc_kxp) <<< 2) + 38'sd32768) >>> 16);
    nd_ky  <= 22'(((38'(nc_kyp) <<< 2) + 38'sd32768) >>> 16);
    nd_wvx <= nc_wvx;
    nd_wvy <= nc_wvy;
    nd_vx  <= nc_vx;
    nd_vy  <= nc_vy;

    ne_kxvx <= 54'(nd_kx * nd_vx);
    ne_kyvx <= 54'(nd_ky * nd_vx);
    ne_kxvy <= 54'(nd_kx * nd_vy);
    ne_kyvy <= 54'(nd_ky * nd_vy);
    ne_wvx  <= nd_wvx;
    ne_wvy  <= nd_wvy;
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      for (int a = 0; a < 6; a++) begin
        acc[a] <= '0;
      end
    end else if (nv[4]) begin
      acc[0] <= acc[0] + ACC_W'(ne_wvx);
      acc[1] <= acc[1] + ACC_W'(ne_wvy);
      acc[2] <= acc[2] + ACC_W'(ne_kxvx);
      acc[3] <= acc[3] + ACC_W'(ne_kyvx);
      acc[4] <= acc[4] + ACC_W'(ne_kxvy);
      acc[5] <= acc[5] + ACC_W'(ne_kyvy);
    end
  end

  // ---------------------------------------------------------------- node memory
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = accept_wr && (int'(in_node_x) < MAX_GRID) && (int'(in_node_y) < MAX_GRID);
      ram_waddr = {AW'(in_node_x), AW'(in_node_y)};
      ram_wdata = s_axis_tdata[77:14];
    end
  end

  mpm_g2p_ram #(
    .WIDTH (64),
    .DEPTH (1 << (2 * AW))
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (node_issue),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {round_sat(acc[5]), round_sat(acc[4]), round_sat(acc[3]),
                       round_sat(acc[2]), round_sat(acc[1]), round_sat(acc[0])};
    end
  end

  // ---------------------------------------------------------------- assertions
  `MPM_G2P_ASSERT_NOW(a_out_src, $rose(m_axis_tvalid), $past(state) == ST_FINISH, "stray result")
  `MPM_G2P_ASSERT_NOW(a_acc_window, nv[4], state == ST_NODES || state == ST_DRAIN, "stray sum")
  `MPM_G2P_ASSERT_NOW(a_weights_ready, state == ST_NODES, sp_v == '0, "weights not settled")
  `MPM_G2P_ASSERT_NEXT(a_write_stays_idle, accept_wr, state == ST_IDLE, "write left idle")

endmodule
`default_nettype wire

// ===== hdl/mpm_g2p_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module mpm_g2p_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
